@@ sv/cbq_pkg.sv @@
// Shared types and constants for the circular byte queue.
`default_nettype none
package cbq_pkg;

  localparam int CapW = 13;  // capacity register width
  localparam int LenW = 12;  // length and count field width

  typedef enum logic [2:0] {
    OP_ENQ  = 3'd0,
    OP_DEQ  = 3'd1,
    OP_PEEK = 3'd2,
    OP_MRD  = 3'd3,
    OP_MWR  = 3'd4,
    OP_CLR  = 3'd5
  } op_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_RANGE = 2'd2
  } status_e;

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_PH0  = 5'b00010,
    S_PH1  = 5'b00100,
    S_MOD  = 5'b01000,
    S_CALC = 5'b10000
  } state_e;

  // per-lane control: lane carries a byte, and its address wrapped past capacity
  typedef struct packed {
    logic act;
    logic wrap;
  } lane_ctl_t;

endpackage
`default_nettype wire

@@ sv/cbq_ram.sv @@
// Generic single-port RAM with registered read.
`default_nettype none
module cbq_ram #(
  parameter int W = 8,
  parameter int D = 512
) (
  input  wire logic                 clk_i,
  input  wire logic                 we_i,
  input  wire logic [$clog2(D)-1:0] addr_i,
  input  wire logic [W-1:0]         wdata_i,
  output logic      [W-1:0]         rdata_o
);

  logic [W-1:0] mem_q [D];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_o <= mem_q[addr_i];
  end

endmodule
`default_nettype wire

@@ sv/cbq_mod.sv @@
// Iterative restoring modulo unit: one quotient bit per cycle.
`default_nettype none
module cbq_mod import cbq_pkg::*; #(
  parameter int XW = 13,
  parameter int PW = 12
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            start_i,
  input  wire logic [XW-1:0]   x_i,
  input  wire logic [CapW-1:0] m_i,
  output logic                 done_o,
  output logic [PW-1:0]        res_o
);

  localparam int CntW = $clog2(XW + 1);

  logic [XW-1:0]   x_q, x_d;
  logic [CapW-1:0] r_q, r_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            run_q, run_d;
  logic [CapW:0]   t;
  logic            done_d;

  always_comb begin
    x_d    = x_q;
    r_d    = r_q;
    cnt_d  = cnt_q;
    run_d  = run_q;
    done_d = 1'b0;
    t      = {r_q, x_q[XW-1]};
    if (start_i) begin
      x_d   = x_i;
      r_d   = '0;
      cnt_d = '0;
      run_d = 1'b1;
    end else if (run_q) begin
      if (t >= {1'b0, m_i}) begin
        r_d = CapW'(t - {1'b0, m_i});
      end else begin
        r_d = t[CapW-1:0];
      end
      x_d   = {x_q[XW-2:0], 1'b0};
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == CntW'(XW - 1)) begin
        run_d  = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      cnt_q  <= '0;
      done_o <= 1'b0;
    end else begin
      run_q  <= run_d;
      cnt_q  <= cnt_d;
      done_o <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q <= x_d;
    r_q <= r_d;
  end

  assign res_o = r_q[PW-1:0];

endmodule
`default_nettype wire

@@ sv/cbq_lane.sv @@
// One byte lane: wrapped address, bank and row, and its read byte select.
`default_nettype none
module cbq_lane import cbq_pkg::*; #(
  parameter int PW  = 12,
  parameter int NW  = 4,
  parameter int NB  = 8,
  parameter int BW  = 3,
  parameter int AW  = 12,
  parameter int RAW = 9,
  parameter int LI  = 0
) (
  input  wire logic [PW-1:0]       base_i,
  input  wire logic [CapW-1:0]     cap_i,
  input  wire logic [NW-1:0]       n_i,
  input  wire logic [NB-1:0][7:0]  rdata_i,
  output lane_ctl_t                ctl_o,
  output logic [BW-1:0]            bank_o,
  output logic [RAW-1:0]           row_o,
  output logic [7:0]               rbyte_o
);

  localparam int SW = (PW + 1 > CapW) ? PW + 1 : CapW;

  logic [SW-1:0] s, capx, a;
  logic [AW-1:0] ax;

  always_comb begin
    s    = SW'(base_i) + SW'(LI);
    capx = SW'(cap_i);
    ctl_o.wrap = (s >= capx);
    a    = ctl_o.wrap ? s - capx : s;
    ctl_o.act  = (NW'(LI) < n_i);
    ax   = AW'(a[PW-1:0]);
    bank_o  = ax[BW-1:0];
    row_o   = RAW'(ax >> BW);
    rbyte_o = rdata_i[bank_o];
  end

endmodule
`default_nettype wire

@@ sv/circular_byte_queue.sv @@
// Circular byte queue: ring buffer of DEPTH bytes in banked RAM, up to LANES bytes per command.
// A command is taken when start_i is high and busy_o is low. Enqueue, dequeue and peek
// move their bytes in the RAM phases PH0 and PH1 (PH1 for bytes whose address wraps past
// capacity), then the new position goes through a bit-serial modulo unit; every command
// ends in the one-cycle result_valid_o strobe, and busy_o drops on the strobe cycle.
// The receiver cannot stall: results must be taken in the cycle they are shown.
`default_nettype none
module circular_byte_queue import cbq_pkg::*; #(
  parameter int DEPTH          = 4096,
  parameter int LANES          = 8,
  parameter int RESERVED_SLOTS = 1
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            start_i,
  output logic                 busy_o,
  input  wire logic [2:0]      opcode_i,
  input  wire logic [11:0]     length_i,
  input  wire logic [63:0]     write_bytes_i,
  input  wire logic            cfg_we_i,
  input  wire logic [12:0]     cfg_wdata_i,
  output logic                 result_valid_o,
  output logic [11:0]          done_count_o,
  output logic [63:0]          read_bytes_o,
  output logic [11:0]          used_bytes_o,
  output logic [11:0]          free_bytes_o,
  output logic [12:0]          read_span_o,
  output logic [12:0]          write_span_o,
  output logic [1:0]           status_o
);

  localparam int PMax  = (DEPTH < 8191) ? DEPTH : 8191;
  localparam int PW    = $clog2(PMax);
  localparam int AW    = $clog2(DEPTH);
  localparam int NB    = (LANES < 2) ? 2 : 2 ** $clog2(LANES);
  localparam int BW    = $clog2(NB);
  localparam int RD    = (DEPTH + NB - 1) / NB;
  localparam int RAW   = $clog2(RD);
  localparam int NW    = $clog2(LANES + 1);
  localparam int XW    = ((PW > LenW) ? PW : LenW) + 1;
  localparam int CapRst = (DEPTH < 4096) ? DEPTH : 4096;

  state_e state_q, state_d;

  logic [CapW-1:0] cap_q;
  logic [PW-1:0]   rp_q, wp_q;
  logic [LenW-1:0] done_q;
  logic [1:0]      st_q;
  logic [NW-1:0]   n_q;
  logic [PW-1:0]   mbase_q;
  logic [XW-1:0]   x_q;
  logic            is_wr_q, is_rd_q, upd_rp_q, upd_wp_q, clr_q;
  logic [63:0]     wbytes_q;
  logic [LANES-1:0][7:0] rbytes_q;
  logic            rd_vld_q, rd_ph_q;

  // fill level from current positions
  logic [CapW-1:0] used_w, free_w, rspan_w, wspan_w;
  always_comb begin
    if (CapW'(rp_q) <= CapW'(wp_q)) begin
      used_w  = CapW'(wp_q) - CapW'(rp_q);
      rspan_w = used_w;
    end else begin
      used_w  = cap_q - CapW'(rp_q) + CapW'(wp_q);
      rspan_w = cap_q - CapW'(rp_q);
    end
    free_w = cap_q - CapW'(RESERVED_SLOTS) - used_w;
    if (wp_q < rp_q) begin
      wspan_w = CapW'(rp_q) - CapW'(wp_q) - CapW'(RESERVED_SLOTS);
    end else if (CapW'(rp_q) < CapW'(RESERVED_SLOTS)) begin
      wspan_w = cap_q - CapW'(wp_q) - (CapW'(RESERVED_SLOTS) - CapW'(rp_q));
    end else begin
      wspan_w = cap_q - CapW'(wp_q);
    end
  end

  // lanes
  logic                  phase;
  lane_ctl_t [LANES-1:0] ctl;
  logic [LANES-1:0][BW-1:0]  bank;
  logic [LANES-1:0][RAW-1:0] row;
  logic [LANES-1:0][7:0]     rbyte;
  logic [NB-1:0][7:0]        bank_rdata;

  assign phase = (state_q == S_PH1);

  for (genvar i = 0; i < LANES; i++) begin : g_lane
    cbq_lane #(
      .PW(PW), .NW(NW), .NB(NB), .BW(BW), .AW(AW), .RAW(RAW), .LI(i)
    ) u_lane (
      .base_i (mbase_q),
      .cap_i  (cap_q),
      .n_i    (n_q),
      .rdata_i(bank_rdata),
      .ctl_o  (ctl[i]),
      .bank_o (bank[i]),
      .row_o  (row[i]),
      .rbyte_o(rbyte[i])
    );
  end

  // bank crossbar: lanes active in the current phase hit distinct banks
  for (genvar b = 0; b < NB; b++) begin : g_bank
    logic           sel;
    logic [RAW-1:0] baddr;
    logic [7:0]     bwd;
    always_comb begin
      sel   = 1'b0;
      baddr = '0;
      bwd   = '0;
      for (int i = 0; i < LANES; i++) begin
        if (ctl[i].act && (ctl[i].wrap == phase) && (bank[i] == BW'(b))) begin
          sel   = 1'b1;
          baddr = row[i];
          bwd   = wbytes_q[8*i +: 8];
        end
      end
    end
    cbq_ram #(.W(8), .D(RD)) u_ram (
      .clk_i  (clk_i),
      .we_i   (sel && is_wr_q && (state_q == S_PH0 || state_q == S_PH1)),
      .addr_i (baddr),
      .wdata_i(bwd),
      .rdata_o(bank_rdata[b])
    );
  end

  // position update unit
  logic            mod_done;
  logic [PW-1:0]   mod_res;
  cbq_mod #(.XW(XW), .PW(PW)) u_mod (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(state_q == S_PH1),
    .x_i    (x_q),
    .m_i    (cap_q),
    .done_o (mod_done),
    .res_o  (mod_res)
  );

  assign busy_o = (state_q != S_IDLE);

  logic accept;
  assign accept = start_i && !busy_o;

  // command decode at accept
  logic [1:0]      st_d;
  logic [NW-1:0]   n_d;
  logic [LenW-1:0] done_d;
  logic [PW-1:0]   base_d;
  logic [XW-1:0]   add_d;
  logic            is_wr_d, is_rd_d, upd_rp_d, upd_wp_d, clr_d;
  always_comb begin
    st_d     = ST_OK;
    n_d      = '0;
    done_d   = '0;
    base_d   = rp_q;
    add_d    = '0;
    is_wr_d  = 1'b0;
    is_rd_d  = 1'b0;
    upd_rp_d = 1'b0;
    upd_wp_d = 1'b0;
    clr_d    = 1'b0;
    unique case (opcode_i)
      OP_ENQ: begin
        base_d = wp_q;
        if (length_i > LenW'(LANES)) begin
          st_d = ST_RANGE;
        end else if (CapW'(length_i) > free_w) begin
          st_d = ST_EMPTY;
        end else begin
          n_d      = NW'(length_i);
          done_d   = length_i;
          add_d    = XW'(length_i);
          is_wr_d  = 1'b1;
          upd_wp_d = 1'b1;
        end
      end
      OP_DEQ, OP_PEEK: begin
        if (length_i > LenW'(LANES)) begin
          st_d = ST_RANGE;
        end else begin
          n_d = (CapW'(length_i) < used_w) ? NW'(length_i) : NW'(used_w);
          if (length_i != '0 && n_d == '0) begin
            st_d = ST_EMPTY;
          end
          done_d   = LenW'(n_d);
          add_d    = XW'(n_d);
          is_rd_d  = 1'b1;
          upd_rp_d = (opcode_i == OP_DEQ);
        end
      end
      OP_MRD: begin
        done_d   = length_i;
        add_d    = XW'(length_i);
        upd_rp_d = 1'b1;
      end
      OP_MWR: begin
        base_d   = wp_q;
        done_d   = length_i;
        add_d    = XW'(length_i);
        upd_wp_d = 1'b1;
      end
      OP_CLR: clr_d = 1'b1;
      default: ;
    endcase
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: if (accept) state_d = S_PH0;
      S_PH0:  state_d = S_PH1;
      S_PH1:  state_d = S_MOD;
      S_MOD:  if (mod_done) state_d = S_CALC;
      S_CALC: state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= S_IDLE;
      cap_q          <= CapW'(CapRst);
      rp_q           <= '0;
      wp_q           <= '0;
      rd_vld_q       <= 1'b0;
      result_valid_o <= 1'b0;
    end else begin
      state_q        <= state_d;
      rd_vld_q       <= is_rd_q && (state_q == S_PH0 || state_q == S_PH1);
      result_valid_o <= (state_q == S_CALC);
      if (cfg_we_i) begin
        if (cfg_wdata_i < CapW'(2)) begin
          cap_q <= CapW'(2);
        end else if (32'(cfg_wdata_i) > 32'(DEPTH)) begin
          cap_q <= CapW'(PMax);
        end else begin
          cap_q <= cfg_wdata_i;
        end
        rp_q <= '0;
        wp_q <= '0;
      end else if (state_q == S_MOD && mod_done) begin
        if (clr_q) begin
          rp_q <= '0;
          wp_q <= '0;
        end else begin
          if (upd_rp_q) rp_q <= mod_res;
          if (upd_wp_q) wp_q <= mod_res;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    rd_ph_q <= phase;
    if (accept) begin
      st_q     <= st_d;
      n_q      <= n_d;
      done_q   <= done_d;
      mbase_q  <= base_d;
      x_q      <= XW'(base_d) + add_d;
      is_wr_q  <= is_wr_d;
      is_rd_q  <= is_rd_d;
      upd_rp_q <= upd_rp_d;
      upd_wp_q <= upd_wp_d;
      clr_q    <= clr_d;
      wbytes_q <= write_bytes_i;
      rbytes_q <= '0;
    end else if (rd_vld_q) begin
      for (int i = 0; i < LANES; i++) begin
        if (ctl[i].act && (ctl[i].wrap == rd_ph_q)) begin
          rbytes_q[i] <= rbyte[i];
        end
      end
    end
    if (state_q == S_CALC) begin
      done_count_o <= done_q;
      read_bytes_o <= 64'(rbytes_q);
      used_bytes_o <= used_w[LenW-1:0];
      free_bytes_o <= free_w[LenW-1:0];
      read_span_o  <= rspan_w;
      write_span_o <= wspan_w;
      status_o     <= st_q;
    end
  end

endmodule
`default_nettype wire

@@ tb/circular_byte_queue_test.sv @@
// Self-checking testbench for the circular byte queue: random and directed commands.
`default_nettype none
module circular_byte_queue_test import cbq_pkg::*;;

  localparam int            Depth    = 4096;
  localparam int            Lanes    = 8;
  localparam int            StallMax = 3000;
  localparam logic [2:0]    OpSpare6 = 3'd6;
  localparam logic [2:0]    OpSpare7 = 3'd7;

  typedef struct packed {
    logic [11:0] done_count;
    logic [63:0] read_bytes;
    logic [11:0] used_bytes;
    logic [11:0] free_bytes;
    logic [12:0] read_span;
    logic [12:0] write_span;
    logic [1:0]  status;
  } queue_word_t;

  class queue_scoreboard;
    int          cap;
    int          rd;
    int          wr;
    logic [7:0]  mem [Depth];
    bit          filled [Depth];
    queue_word_t pending [$];
    int          mismatches;
    int          checked;

    function new();
      cap = Depth;
      rd = 0;
      wr = 0;
      mismatches = 0;
      checked = 0;
      foreach (filled[i]) filled[i] = 0;
    endfunction

    function void set_capacity(logic [12:0] v);
      int c;
      c = int'(v);
      if (c < 2) c = 2;
      if (c > Depth) c = Depth;
      cap = c;
      rd = 0;
      wr = 0;
    endfunction

    function int used_now();
      return (rd <= wr) ? wr - rd : cap - rd + wr;
    endfunction

    // true when every byte a dequeue/peek of len would return was written at some point
    function bit readable(int len);
      int n;
      n = (len < used_now()) ? len : used_now();
      for (int i = 0; i < n; i++)
        if (!filled[(rd + i) % cap]) return 0;
      return 1;
    endfunction

    function void note_command(logic [2:0] op, logic [11:0] len, logic [63:0] wb);
      queue_word_t w;
      int          used;
      int          room;
      int          n;
      int          l;
      l = int'(len);
      w.done_count = '0;
      w.read_bytes = '0;
      w.status = ST_OK;
      used = used_now();
      room = cap - 1 - used;
      case (op)
        OP_ENQ: begin
          if (l > Lanes) w.status = ST_RANGE;
          else if (l > room) w.status = ST_EMPTY;
          else begin
            for (int i = 0; i < l; i++) begin
              mem[(wr + i) % cap] = wb[8*i +: 8];
              filled[(wr + i) % cap] = 1;
            end
            wr = (wr + l) % cap;
            w.done_count = 12'(l);
          end
        end
        OP_DEQ, OP_PEEK: begin
          if (l > Lanes) w.status = ST_RANGE;
          else begin
            n = (l < used) ? l : used;
            if (l > 0 && n == 0) w.status = ST_EMPTY;
            for (int i = 0; i < n; i++) w.read_bytes[8*i +: 8] = mem[(rd + i) % cap];
            if (op == OP_DEQ) rd = (rd + n) % cap;
            w.done_count = 12'(n);
          end
        end
        OP_MRD: begin
          rd = (rd + l) % cap;
          w.done_count = 12'(l);
        end
        OP_MWR: begin
          wr = (wr + l) % cap;
          w.done_count = 12'(l);
        end
        OP_CLR: begin
          rd = 0;
          wr = 0;
        end
        default: ;
      endcase
      used = used_now();
      w.used_bytes = 12'(used);
      w.free_bytes = 12'(cap - 1 - used);
      w.read_span = 13'((rd <= wr) ? wr - rd : cap - rd);
      if (wr < rd) w.write_span = 13'(rd - wr - 1);
      else if (rd < 1) w.write_span = 13'(cap - wr - 1);
      else w.write_span = 13'(cap - wr);
      pending.push_back(w);
    endfunction

    function void check_result(queue_word_t got);
      queue_word_t exp;
      checked++;
      if (pending.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result word, nothing pending");
        return;
      end
      exp = pending.pop_front();
      if (got !== exp) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("mismatch: exp done=%0d rb=%h used=%0d free=%0d rs=%0d ws=%0d st=%0d",
                   exp.done_count, exp.read_bytes, exp.used_bytes, exp.free_bytes,
                   exp.read_span, exp.write_span, exp.status);
          $display("          got done=%0d rb=%h used=%0d free=%0d rs=%0d ws=%0d st=%0d",
                   got.done_count, got.read_bytes, got.used_bytes, got.free_bytes,
                   got.read_span, got.write_span, got.status);
        end
      end
    endfunction
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        start_i = 1'b0;
  logic        busy_o;
  logic [2:0]  opcode_i = '0;
  logic [11:0] length_i = '0;
  logic [63:0] write_bytes_i = '0;
  logic        cfg_we_i = 1'b0;
  logic [12:0] cfg_wdata_i = '0;
  logic        result_valid_o;
  logic [11:0] done_count_o;
  logic [63:0] read_bytes_o;
  logic [11:0] used_bytes_o;
  logic [11:0] free_bytes_o;
  logic [12:0] read_span_o;
  logic [12:0] write_span_o;
  logic [1:0]  status_o;

  queue_scoreboard sb = new();
  int idle_pct = 0;
  int sent = 0;
  int quiet = 0;
  int cap_writes = 0;

  circular_byte_queue dut (
    .clk_i, .rst_ni, .start_i, .busy_o, .opcode_i, .length_i, .write_bytes_i,
    .cfg_we_i, .cfg_wdata_i, .result_valid_o, .done_count_o, .read_bytes_o,
    .used_bytes_o, .free_bytes_o, .read_span_o, .write_span_o, .status_o
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    queue_word_t got;
    if (rst_ni && result_valid_o) begin
      got.done_count = done_count_o;
      got.read_bytes = read_bytes_o;
      got.used_bytes = used_bytes_o;
      got.free_bytes = free_bytes_o;
      got.read_span = read_span_o;
      got.write_span = write_span_o;
      got.status = status_o;
      sb.check_result(got);
    end
    if (rst_ni && ((start_i && !busy_o) || result_valid_o)) quiet <= 0;
    else quiet <= quiet + 1;
  end

  always @(posedge clk_i) begin
    if (quiet >= StallMax) begin
      $display("watchdog: no activity for %0d cycles", StallMax);
      $display("FAILURE");
      $finish;
    end
  end

  // called at a rising edge; returns at the rising edge that took the word, or after a random idle gap with start_i low
  task automatic send(logic [2:0] op, logic [11:0] len, logic [63:0] wb);
    // a read across never-written bytes is not allowed, turn it into a move
    if ((op == OP_DEQ || op == OP_PEEK) && len <= Lanes && !sb.readable(len)) op = OP_MRD;
    start_i <= 1'b1;
    opcode_i <= op;
    length_i <= len;
    write_bytes_i <= wb;
    do @(negedge clk_i); while (busy_o);
    sb.note_command(op, len, wb);
    sent++;
    @(posedge clk_i);
    if ($urandom_range(99) < idle_pct) begin
      start_i <= 1'b0;
      repeat ($urandom_range(1, ($urandom_range(9) == 0) ? 40 : 4)) @(posedge clk_i);
    end
  endtask

  task automatic drain();
    start_i <= 1'b0;
    @(posedge clk_i);
    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  task automatic write_capacity(logic [12:0] v);
    drain();
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    sb.set_capacity(v);
    cap_writes++;
    @(posedge clk_i);
  endtask

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  task automatic random_command();
    int          pick;
    logic [2:0]  op;
    logic [11:0] len;
    pick = $urandom_range(99);
    if (pick < 40) op = OP_ENQ;
    else if (pick < 65) op = OP_DEQ;
    else if (pick < 77) op = OP_PEEK;
    else if (pick < 84) op = OP_MRD;
    else if (pick < 90) op = OP_MWR;
    else if (pick < 94) op = OP_CLR;
    else op = 3'($urandom_range(7));
    if (op == OP_MRD || op == OP_MWR || $urandom_range(19) == 0)
      len = ($urandom_range(3) == 0) ? 12'($urandom) : 12'($urandom_range(2 * Lanes));
    else
      len = 12'($urandom_range(Lanes));
    send(op, len, rand64());
  endtask

  initial begin
    logic [12:0] caps [9];
    caps = '{13'd4096, 13'd2, 13'd9, 13'd16, 13'd37, 13'd3, 13'd0, 13'd8191, 13'd300};
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed corners at reset capacity
    send(OP_ENQ, 12'd0, '0);
    send(OP_ENQ, 12'd8, '1);
    send(OP_PEEK, 12'd0, '0);
    send(OP_DEQ, 12'd8, '0);
    send(OP_DEQ, 12'd4, '0);
    send(OP_ENQ, 12'd9, '1);
    send(OP_ENQ, 12'hfff, '1);
    send(OP_PEEK, 12'd9, '0);
    send(OpSpare6, 12'd3, '1);
    send(OpSpare7, 12'hfff, '1);
    send(OP_MRD, 12'hfff, '0);
    send(OP_MWR, 12'hfff, '0);
    send(OP_CLR, 12'hfff, '1);
    send(OP_ENQ, 12'd8, 64'h0123_4567_89ab_cdef);
    send(OP_PEEK, 12'd8, '0);
    send(OP_DEQ, 12'd3, '0);
    send(OP_DEQ, 12'd8, '0);
    // smallest ring holds one byte
    write_capacity(13'd2);
    send(OP_ENQ, 12'd1, 64'hff);
    send(OP_ENQ, 12'd1, 64'h11);
    send(OP_DEQ, 12'd1, '0);
    send(OP_ENQ, 12'd2, '1);
    send(OP_MRD, 12'd1, '0);
    send(OP_CLR, 12'd0, '0);

    for (int ph = 0; ph < 9; ph++) begin
      write_capacity(caps[ph]);
      case (ph % 4)
        0: idle_pct = 0;
        1: idle_pct = 57;
        2: idle_pct = 34;
        default: idle_pct = 57;
      endcase
      for (int k = 0; k < 145; k++) begin
        random_command();
        if (ph == 4 && k == 70) drain();
      end
    end
    write_capacity(13'($urandom_range(2, 4096)));
    for (int k = 0; k < 20; k++) random_command();

    drain();
    $display("run covered %0d commands over %0d capacity settings, %0d results checked",
             sent, cap_writes, sb.checked);
    $display("mismatches: %0d, words left pending: %0d", sb.mismatches, sb.pending.size());
    if (sb.mismatches == 0 && sb.pending.size() == 0) $display("SUCCESS");
    else $display("FAILURE");
    $finish;
  end

endmodule
`default_nettype wire
